>>> hdl/tpjq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpjq_pkg;

    localparam int FUNC_W   = 3;
    localparam int DUE_W    = 32;
    localparam int PRIO_W   = 2;
    localparam int IDENT_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int LIMIT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TAKE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SHUTDOWN = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_STOPPED  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
    localparam logic [IDENT_W-1:0] IDENT_FIRST = 32'd1;
    localparam logic [DUE_W-1:0]   TICK_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCHED_FIND,
        ST_CANCEL_SCAN,
        ST_CANCEL_FLUSH,
        ST_TAKE_SCAN,
        ST_TAKE_FLUSH,
        ST_TAKE_DECIDE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [DUE_W-1:0]   due;
        logic [PRIO_W-1:0]  prio;
        logic [IDENT_W-1:0] ident;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic scan_clr;
        logic scan_run;
        logic sched_write;
        logic eval_cancel;
        logic eval_take;
        logic take_decide;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              sched_ok;
        logic              cancel_ok;
        logic              stopped;
        logic              free_here;
        logic              scan_last;
        logic              take_again;
        logic              out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hdl/tpjq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tpjq_req_if;
    logic                          valid;
    logic                          ready;
    logic [tpjq_pkg::FUNC_W-1:0]   func;
    logic [tpjq_pkg::DUE_W-1:0]    due_tick;
    logic [tpjq_pkg::PRIO_W-1:0]   urgency;
    logic [tpjq_pkg::IDENT_W-1:0]  target_id;
    logic                          immediate_mode;

    modport source (output valid, func, due_tick, urgency, target_id, immediate_mode,
                    input ready);
    modport sink   (input valid, func, due_tick, urgency, target_id, immediate_mode,
                    output ready);
endinterface

interface tpjq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tpjq_pkg::STATUS_W-1:0] status;
    logic [tpjq_pkg::IDENT_W-1:0]  job_ident;
    logic [tpjq_pkg::COUNT_W-1:0]  queued_count;
    logic                          is_accepting;

    modport source (output valid, status, job_ident, queued_count, is_accepting,
                    input ready);
    modport sink   (input valid, status, job_ident, queued_count, is_accepting,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/tpjq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tpjq_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tpjq_pkg::LIMIT_W-1:0]    cfg_wr_data,
    input  wire logic [tpjq_pkg::FUNC_W-1:0]     func,
    input  wire logic [tpjq_pkg::DUE_W-1:0]      due_tick,
    input  wire logic [tpjq_pkg::PRIO_W-1:0]     urgency,
    input  wire logic [tpjq_pkg::IDENT_W-1:0]    target_id,
    input  wire logic                            immediate_mode,
    input  wire tpjq_pkg::cmd_t                  cmd,
    output tpjq_pkg::sts_t                       sts,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [tpjq_pkg::STATUS_W-1:0]        out_status,
    output logic [tpjq_pkg::IDENT_W-1:0]         out_ident,
    output logic [tpjq_pkg::COUNT_W-1:0]         out_count,
    output logic                                 out_accepting
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > tpjq_pkg::LIMIT_W) ? CW : tpjq_pkg::LIMIT_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

    // latched request
    logic [tpjq_pkg::FUNC_W-1:0]   req_func_reg;
    logic [tpjq_pkg::DUE_W-1:0]    req_due_reg;
    logic [tpjq_pkg::PRIO_W-1:0]   req_prio_reg;
    logic [tpjq_pkg::IDENT_W-1:0]  req_target_reg;
    logic                          req_imm_reg;

    // entry storage
    tpjq_pkg::entry_t ent_mem [TABLE_DEPTH];
    logic             cncl_mem [TABLE_DEPTH];
    tpjq_pkg::entry_t ent_rd_reg;
    logic             cncl_rd_reg;

    // architectural state
    logic [TABLE_DEPTH-1:0]          valid_reg;
    logic [CW-1:0]                   count_reg;
    logic [tpjq_pkg::IDENT_W-1:0]    issue_reg;
    logic [tpjq_pkg::DUE_W-1:0]      now_reg;
    logic                            accept_reg;
    logic                            stop_reg;
    logic                            graceful_reg;
    logic [tpjq_pkg::LIMIT_W-1:0]    limit_reg;

    // scan pipeline
    logic [IW-1:0]                   scan_idx_reg;
    logic                            rd_vld_reg;
    logic [IW-1:0]                   rd_idx_reg;
    logic                            best_vld_reg;
    logic [IW-1:0]                   best_idx_reg;
    logic [tpjq_pkg::DUE_W-1:0]      best_due_reg;
    logic [tpjq_pkg::PRIO_W-1:0]     best_prio_reg;
    logic [tpjq_pkg::IDENT_W-1:0]    best_ident_reg;
    logic                            best_cncl_reg;

    // pending result and output stage
    logic [tpjq_pkg::STATUS_W-1:0]   res_status_reg;
    logic [tpjq_pkg::IDENT_W-1:0]    res_ident_reg;
    logic                            out_valid_reg;
    logic [tpjq_pkg::STATUS_W-1:0]   out_status_reg;
    logic [tpjq_pkg::IDENT_W-1:0]    out_ident_reg;
    logic [tpjq_pkg::COUNT_W-1:0]    out_count_reg;
    logic                            out_accept_reg;

    logic          full;
    logic          sched_ok;
    logic          rd_hit;
    logic          rd_before;
    logic          best_late;
    logic          take_again;
    logic          cncl_we;
    logic [IW-1:0] cncl_waddr;
    logic          cncl_wdata;

    assign full      = (LW'(count_reg) >= LW'(limit_reg)) || (count_reg >= DEPTH_CNT);
    assign sched_ok  = accept_reg && !full;
    assign rd_hit    = rd_vld_reg && valid_reg[rd_idx_reg];
    assign best_late = best_due_reg > now_reg;
    assign take_again = best_vld_reg && !best_late && best_cncl_reg;

    // earliest due, then higher urgency, then lower id
    always_comb
    begin
        if (!best_vld_reg)
            rd_before = 1'b1;
        else if (ent_rd_reg.due != best_due_reg)
            rd_before = ent_rd_reg.due < best_due_reg;
        else if (ent_rd_reg.prio != best_prio_reg)
            rd_before = ent_rd_reg.prio > best_prio_reg;
        else
            rd_before = ent_rd_reg.ident < best_ident_reg;
    end

    always_comb
    begin
        cncl_we    = 1'b0;
        cncl_waddr = scan_idx_reg;
        cncl_wdata = 1'b0;
        if (cmd.sched_write)
        begin
            cncl_we = 1'b1;
        end
        else if (cmd.eval_cancel && rd_hit && (ent_rd_reg.ident == req_target_reg))
        begin
            cncl_we    = 1'b1;
            cncl_waddr = rd_idx_reg;
            cncl_wdata = 1'b1;
        end
    end

    always_comb
    begin
        sts.func       = req_func_reg;
        sts.sched_ok   = sched_ok;
        sts.cancel_ok  = accept_reg;
        sts.stopped    = stop_reg;
        sts.free_here  = !valid_reg[scan_idx_reg];
        sts.scan_last  = scan_idx_reg == LAST_IDX;
        sts.take_again = take_again;
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            issue_reg     <= tpjq_pkg::IDENT_FIRST;
            now_reg       <= '0;
            accept_reg    <= 1'b1;
            stop_reg      <= 1'b0;
            graceful_reg  <= 1'b1;
            limit_reg     <= tpjq_pkg::LIMIT_RESET;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            best_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;

            if (cmd.scan_clr)
            begin
                scan_idx_reg <= '0;
                rd_vld_reg   <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                rd_vld_reg   <= 1'b1;
            end
            else
            begin
                rd_vld_reg <= 1'b0;
            end

            if (cmd.scan_clr)
                best_vld_reg <= 1'b0;
            else if (cmd.eval_take && rd_hit && rd_before)
                best_vld_reg <= 1'b1;

            if (cmd.exec)
            begin
                case (req_func_reg)
                    tpjq_pkg::FUNC_TICK:
                    begin
                        if (now_reg != tpjq_pkg::TICK_MAX)
                            now_reg <= now_reg + 1'b1;
                    end
                    tpjq_pkg::FUNC_SHUTDOWN:
                    begin
                        accept_reg   <= 1'b0;
                        graceful_reg <= !req_imm_reg;
                        if (req_imm_reg)
                        begin
                            valid_reg <= '0;
                            count_reg <= '0;
                            stop_reg  <= 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            stop_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.sched_write)
            begin
                valid_reg[scan_idx_reg] <= 1'b1;
                count_reg               <= count_reg + 1'b1;
                issue_reg               <= issue_reg + 1'b1;
            end

            if (cmd.take_decide)
            begin
                if (!best_vld_reg)
                begin
                    if (!accept_reg && graceful_reg)
                        stop_reg <= 1'b1;
                end
                else if (!best_late)
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    count_reg               <= count_reg - 1'b1;
                end
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_func_reg   <= func;
            req_due_reg    <= due_tick;
            req_prio_reg   <= urgency;
            req_target_reg <= target_id;
            req_imm_reg    <= immediate_mode;
        end

        ent_rd_reg  <= ent_mem[scan_idx_reg];
        cncl_rd_reg <= cncl_mem[scan_idx_reg];
        rd_idx_reg  <= scan_idx_reg;

        if (cmd.sched_write)
            ent_mem[scan_idx_reg] <= '{due: req_due_reg, prio: req_prio_reg, ident: issue_reg};
        if (cncl_we)
            cncl_mem[cncl_waddr] <= cncl_wdata;

        if (cmd.eval_take && rd_hit && rd_before)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_due_reg   <= ent_rd_reg.due;
            best_prio_reg  <= ent_rd_reg.prio;
            best_ident_reg <= ent_rd_reg.ident;
            best_cncl_reg  <= cncl_rd_reg;
        end

        if (cmd.exec)
        begin
            // an accepted cancel echoes its target, everything else starts at zero
            res_ident_reg <= ((req_func_reg == tpjq_pkg::FUNC_CANCEL) && accept_reg)
                             ? req_target_reg : '0;
            case (req_func_reg)
                tpjq_pkg::FUNC_SCHEDULE:
                    res_status_reg <= sched_ok ? tpjq_pkg::STATUS_OK
                                               : tpjq_pkg::STATUS_REJECTED;
                tpjq_pkg::FUNC_CANCEL:
                    res_status_reg <= accept_reg ? tpjq_pkg::STATUS_OK
                                                 : tpjq_pkg::STATUS_REJECTED;
                tpjq_pkg::FUNC_TICK:
                    res_status_reg <= tpjq_pkg::STATUS_OK;
                tpjq_pkg::FUNC_TAKE:
                    res_status_reg <= stop_reg ? tpjq_pkg::STATUS_STOPPED
                                               : tpjq_pkg::STATUS_NONE;
                tpjq_pkg::FUNC_SHUTDOWN:
                    res_status_reg <= tpjq_pkg::STATUS_OK;
                default:
                    res_status_reg <= tpjq_pkg::STATUS_REJECTED;
            endcase
        end

        if (cmd.sched_write)
            res_ident_reg <= issue_reg;

        if (cmd.take_decide)
        begin
            if (!best_vld_reg)
                res_status_reg <= (!accept_reg && graceful_reg) ? tpjq_pkg::STATUS_STOPPED
                                                                : tpjq_pkg::STATUS_NONE;
            else if (best_late)
                res_status_reg <= tpjq_pkg::STATUS_NONE;
            else if (!best_cncl_reg)
            begin
                res_status_reg <= tpjq_pkg::STATUS_OK;
                res_ident_reg  <= best_ident_reg;
            end
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_ident_reg  <= res_ident_reg;
            out_count_reg  <= tpjq_pkg::COUNT_W'(count_reg);
            out_accept_reg <= accept_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_ident     = out_ident_reg;
    assign out_count     = out_count_reg;
    assign out_accepting = out_accept_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("entry count differs from number of valid entries");

    a_stop_not_accepting: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> !accept_reg)
        else $error("stopped while still accepting");

    a_issue_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.sched_write |=> $stable(issue_reg))
        else $error("id counter moved without a schedule write");

endmodule

`default_nettype wire

>>> hdl/tpjq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tpjq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tpjq_pkg::sts_t sts,
    output tpjq_pkg::cmd_t      cmd
);

    tpjq_pkg::state_t state_reg;
    tpjq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tpjq_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpjq_pkg::ST_IDLE:
                if (in_valid)
                    state_next = tpjq_pkg::ST_DISPATCH;
            tpjq_pkg::ST_DISPATCH:
            begin
                case (sts.func)
                    tpjq_pkg::FUNC_SCHEDULE:
                        state_next = sts.sched_ok ? tpjq_pkg::ST_SCHED_FIND
                                                  : tpjq_pkg::ST_RESULT;
                    tpjq_pkg::FUNC_CANCEL:
                        state_next = sts.cancel_ok ? tpjq_pkg::ST_CANCEL_SCAN
                                                   : tpjq_pkg::ST_RESULT;
                    tpjq_pkg::FUNC_TAKE:
                        state_next = sts.stopped ? tpjq_pkg::ST_RESULT
                                                 : tpjq_pkg::ST_TAKE_SCAN;
                    default:
                        state_next = tpjq_pkg::ST_RESULT;
                endcase
            end
            tpjq_pkg::ST_SCHED_FIND:
                if (sts.free_here)
                    state_next = tpjq_pkg::ST_RESULT;
            tpjq_pkg::ST_CANCEL_SCAN:
                if (sts.scan_last)
                    state_next = tpjq_pkg::ST_CANCEL_FLUSH;
            tpjq_pkg::ST_CANCEL_FLUSH:
                state_next = tpjq_pkg::ST_RESULT;
            tpjq_pkg::ST_TAKE_SCAN:
                if (sts.scan_last)
                    state_next = tpjq_pkg::ST_TAKE_FLUSH;
            tpjq_pkg::ST_TAKE_FLUSH:
                state_next = tpjq_pkg::ST_TAKE_DECIDE;
            tpjq_pkg::ST_TAKE_DECIDE:
                state_next = sts.take_again ? tpjq_pkg::ST_TAKE_SCAN
                                            : tpjq_pkg::ST_RESULT;
            tpjq_pkg::ST_RESULT:
                if (sts.out_free)
                    state_next = tpjq_pkg::ST_IDLE;
            default:
                state_next = tpjq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            tpjq_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            tpjq_pkg::ST_DISPATCH:
            begin
                cmd.exec     = 1'b1;
                cmd.scan_clr = 1'b1;
            end
            tpjq_pkg::ST_SCHED_FIND:
            begin
                cmd.sched_write = sts.free_here;
                cmd.scan_run    = !sts.free_here;
            end
            tpjq_pkg::ST_CANCEL_SCAN:
            begin
                cmd.scan_run    = 1'b1;
                cmd.eval_cancel = 1'b1;
            end
            tpjq_pkg::ST_CANCEL_FLUSH:
                cmd.eval_cancel = 1'b1;
            tpjq_pkg::ST_TAKE_SCAN:
            begin
                cmd.scan_run  = 1'b1;
                cmd.eval_take = 1'b1;
            end
            tpjq_pkg::ST_TAKE_FLUSH:
                cmd.eval_take = 1'b1;
            tpjq_pkg::ST_TAKE_DECIDE:
            begin
                cmd.take_decide = 1'b1;
                cmd.scan_clr    = 1'b1;
            end
            tpjq_pkg::ST_RESULT:
                cmd.out_load = sts.out_free;
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/timed_priority_job_queue_core.sv
// Tick, shutdown, rejected requests and a take while stopped go from dispatch straight
//   to the result beat; schedule first walks the table up to the first free entry.
// Cancel scans the whole table; take scans it too, and scans it once more
//   for every cancelled entry dropped on the way, the scan reading one entry per cycle.
// Throughput: one request at a time; the next is taken while a result beat waits.
// Reset: table empty, tick 0, first id 1, accepting, limit 16; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module timed_priority_job_queue_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpjq_pkg::LIMIT_W-1:0]  cfg_wr_data,
    tpjq_req_if.sink                           req,
    tpjq_rsp_if.source                         rsp
);

    // Command and status between the sequencer and the table datapath
    tpjq_pkg::cmd_t cmd;
    tpjq_pkg::sts_t sts;

    // Sequencer: accept one request beat, walk the table as the function needs,
    // then hold the finished result until the output stage is free.
    tpjq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: entry memories, valid bits, tick and id counters, the scan
    // pipeline that tracks the best due entry, and the registered result beat.
    tpjq_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .func           (req.func),
        .due_tick       (req.due_tick),
        .urgency        (req.urgency),
        .target_id      (req.target_id),
        .immediate_mode (req.immediate_mode),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_status     (rsp.status),
        .out_ident      (rsp.job_ident),
        .out_count      (rsp.queued_count),
        .out_accepting  (rsp.is_accepting)
    );

endmodule

`default_nettype wire

>>> bench/timed_priority_job_queue_core_tb.sv
`timescale 1ns / 1ps

module timed_priority_job_queue_core_tb;

    import tpjq_pkg::*;

    localparam int DEPTH = 16;

    // Priority levels; the fourth value is legal and ranks above high
    localparam logic [PRIO_W-1:0] URG_LOW    = 2'd0;
    localparam logic [PRIO_W-1:0] URG_NORMAL = 2'd1;
    localparam logic [PRIO_W-1:0] URG_HIGH   = 2'd2;
    localparam logic [PRIO_W-1:0] URG_ABOVE  = 2'd3;

    // Shutdown modes
    localparam logic IMM_GRACEFUL = 1'b0;
    localparam logic IMM_DROP     = 1'b1;

    // Function codes the block does not define
    localparam logic [FUNC_W-1:0] FUNC_BAD_FIRST = FUNC_SHUTDOWN + 1'b1;
    localparam logic [FUNC_W-1:0] FUNC_BAD_LAST  = {FUNC_W{1'b1}};

    localparam logic [LIMIT_W-1:0] LIMIT_ZERO = '0;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX  = '1;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PRINT_CAP     = 100;
    // Worst case is roughly 1100 beats, each a take that drops all sixteen entries as
    // cancelled, plus stalls on both sides; allow several times that.
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [DUE_W-1:0]   due;
        logic [PRIO_W-1:0]  urg;
        logic [IDENT_W-1:0] target;
        logic               imm;
    } job_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDENT_W-1:0]  ident;
        logic [COUNT_W-1:0]  count;
        logic                accepting;
    } job_rsp_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;

    tpjq_req_if req_bus();
    tpjq_rsp_if rsp_bus();

    timed_priority_job_queue_core #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_bus),
        .rsp         (rsp_bus)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the job table and its control flags
    // ------------------------------------------------------------------
    bit                 tbl_live [DEPTH];
    bit                 tbl_void [DEPTH];   // cancelled, dropped when reached
    logic [DUE_W-1:0]   tbl_due  [DEPTH];
    logic [PRIO_W-1:0]  tbl_urg  [DEPTH];
    logic [IDENT_W-1:0] tbl_id   [DEPTH];
    logic [IDENT_W-1:0] next_id;
    logic [DUE_W-1:0]   now_tick;
    bit                 accepting;
    bit                 halted;
    bit                 drain_graceful;
    logic [LIMIT_W-1:0] limit_reg;

    // Answers still owed by the block, oldest first
    job_rsp_t answer_q [$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned rx_hold_cycles;
    int unsigned mismatch_total;
    int unsigned cycle_count;

    function automatic int live_count();
        int n;
        int i;
        n = 0;
        for (i = 0; i < DEPTH; i++)
            if (tbl_live[i])
                n++;
        return n;
    endfunction

    // Order: earlier due tick, then higher urgency, then lower id
    function automatic bit ahead_of(input int a, input int b);
        if (tbl_due[a] != tbl_due[b])
            return tbl_due[a] < tbl_due[b];
        if (tbl_urg[a] != tbl_urg[b])
            return tbl_urg[a] > tbl_urg[b];
        return tbl_id[a] < tbl_id[b];
    endfunction

    function automatic int earliest();
        int best;
        int i;
        best = -1;
        for (i = 0; i < DEPTH; i++)
            if (tbl_live[i] && (best < 0 || ahead_of(i, best)))
                best = i;
        return best;
    endfunction

    // Apply one request to the shadow table and return the answer it earns
    function automatic job_rsp_t predict_answer(input job_req_t r);
        job_rsp_t a;
        int       slot;
        int       cap;
        int       i;
        bit       settled;
        a = '0;
        a.status = STATUS_OK;
        case (r.func)
            FUNC_SCHEDULE:
            begin
                // a limit above the table depth acts as the depth
                cap = (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
                slot = -1;
                for (i = DEPTH - 1; i >= 0; i--)
                    if (!tbl_live[i])
                        slot = i;
                if (!accepting || live_count() >= cap || slot < 0)
                    a.status = STATUS_REJECTED;
                else
                begin
                    tbl_live[slot] = 1'b1;
                    tbl_void[slot] = 1'b0;
                    tbl_due[slot]  = r.due;
                    tbl_urg[slot]  = r.urg;
                    tbl_id[slot]   = next_id;
                    a.ident        = next_id;
                    next_id        = next_id + 1'b1;
                end
            end
            FUNC_CANCEL:
            begin
                if (!accepting)
                    a.status = STATUS_REJECTED;
                else
                begin
                    // unknown ids change nothing; every live match is marked
                    for (i = 0; i < DEPTH; i++)
                        if (tbl_live[i] && tbl_id[i] == r.target)
                            tbl_void[i] = 1'b1;
                    a.ident = r.target;
                end
            end
            FUNC_TICK:
            begin
                if (now_tick != TICK_MAX)
                    now_tick = now_tick + 1'b1;
            end
            FUNC_TAKE:
            begin
                settled = 1'b0;
                while (!settled)
                begin
                    settled = 1'b1;
                    slot = earliest();
                    if (halted)
                        a.status = STATUS_STOPPED;
                    else if (slot < 0)
                    begin
                        // empty table ends a graceful drain
                        if (!accepting && drain_graceful)
                        begin
                            halted   = 1'b1;
                            a.status = STATUS_STOPPED;
                        end
                        else
                            a.status = STATUS_NONE;
                    end
                    else if (tbl_due[slot] > now_tick)
                        a.status = STATUS_NONE;
                    else
                    begin
                        tbl_live[slot] = 1'b0;
                        // drop cancelled entries silently and look again
                        if (tbl_void[slot])
                            settled = 1'b0;
                        else
                            a.ident = tbl_id[slot];
                    end
                end
            end
            FUNC_SHUTDOWN:
            begin
                accepting      = 1'b0;
                drain_graceful = !r.imm;
                if (r.imm)
                begin
                    for (i = 0; i < DEPTH; i++)
                        tbl_live[i] = 1'b0;
                    halted = 1'b1;
                end
                else if (live_count() == 0)
                    halted = 1'b1;
            end
            default:
                a.status = STATUS_REJECTED;
        endcase
        a.count     = COUNT_W'(live_count());
        a.accepting = accepting;
        return a;
    endfunction

    function automatic job_req_t make_req(input logic [FUNC_W-1:0] f,
                                          input logic [DUE_W-1:0] d,
                                          input logic [PRIO_W-1:0] u,
                                          input logic [IDENT_W-1:0] t,
                                          input logic m);
        job_req_t r;
        r.func   = f;
        r.due    = d;
        r.urg    = u;
        r.target = t;
        r.imm    = m;
        return r;
    endfunction

    // Random request for the accepting phase. Shutdown is left out: it ends
    // acceptance for good and only the closing test may issue it.
    function automatic job_req_t draw_request();
        job_req_t    r;
        int unsigned pick;
        int unsigned span;
        int unsigned sel;
        r.func   = FUNC_TICK;
        r.due    = $urandom;
        r.urg    = PRIO_W'($urandom);
        r.target = $urandom;
        r.imm    = 1'($urandom);
        pick = $urandom_range(99);
        span = $urandom_range(7);
        sel  = $urandom_range(9);
        if (pick < 35)
        begin
            r.func = FUNC_SCHEDULE;
            // keep due ticks near now so entries come due; some are overdue
            if ($urandom_range(5) == 0)
                r.due = (now_tick > span) ? now_tick - span : '0;
            else
                r.due = now_tick + span;
        end
        else if (pick < 50)
        begin
            r.func = FUNC_CANCEL;
            // mostly recent ids, some not yet issued, some arbitrary
            if (sel < 7)
                r.target = next_id - $urandom_range(12, 1);
            else if (sel == 7)
                r.target = next_id;
            else if (sel == 8)
                r.target = next_id + $urandom_range(4, 1);
        end
        else if (pick < 70)
            r.func = FUNC_TICK;
        else if (pick < 97)
            r.func = FUNC_TAKE;
        else
            r.func = FUNC_W'($urandom_range(FUNC_BAD_LAST, FUNC_BAD_FIRST));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Valid stays high after a beat; the next call drops valid
    // while it draws idle cycles, then puts up the new payload.
    // ------------------------------------------------------------------
    task automatic send_beat(input job_req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.func           <= r.func;
        req_bus.due_tick       <= r.due;
        req_bus.urgency        <= r.urg;
        req_bus.target_id      <= r.target;
        req_bus.immediate_mode <= r.imm;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        answer_q.push_back(predict_answer(r));
    endtask

    // Stop offering and hold until every owed answer has come back
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the queue limit while the block is idle
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        limit_reg = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_total++;
        if (mismatch_total <= PRINT_CAP)
            $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles != 0)
            begin
                rsp_bus.ready <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end
            else
                rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Compare every accepted result beat against the oldest owed answer
    always @(posedge clk)
    begin
        job_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (answer_q.size() == 0)
                flag_mismatch("result beat with nothing owed", '0, rsp_bus.job_ident);
            else
            begin
                want = answer_q.pop_front();
                if (rsp_bus.status !== want.status)
                    flag_mismatch("status", want.status, rsp_bus.status);
                if (rsp_bus.job_ident !== want.ident)
                    flag_mismatch("job_ident", want.ident, rsp_bus.job_ident);
                if (rsp_bus.queued_count !== want.count)
                    flag_mismatch("queued_count", want.count, rsp_bus.queued_count);
                if (rsp_bus.is_accepting !== want.accepting)
                    flag_mismatch("is_accepting", want.accepting, rsp_bus.is_accepting);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed_priority_job_queue_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ordering rules, cancel handling and odd function codes, from reset
    task automatic test_directed_ordering();
        logic [IDENT_W-1:0] unissued;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // empty table while accepting: nothing ready, no stop
        send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
        // same due tick for four entries: urgency first, then lower id
        send_beat(make_req(FUNC_SCHEDULE, 32'd2, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_SCHEDULE, 32'd2, URG_HIGH, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_SCHEDULE, 32'd2, URG_HIGH, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_SCHEDULE, 32'd2, URG_ABOVE, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_SCHEDULE, 32'd0, URG_NORMAL, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_SCHEDULE, 32'd1, URG_NORMAL, '0, IMM_GRACEFUL));
        // cancel the entry due at tick 1, an id not yet issued, and an unknown id
        send_beat(make_req(FUNC_CANCEL, '0, URG_LOW, next_id - 1'b1, IMM_GRACEFUL));
        unissued = next_id + 1'b1;
        send_beat(make_req(FUNC_CANCEL, '0, URG_LOW, unissued, IMM_GRACEFUL));
        send_beat(make_req(FUNC_CANCEL, '1, URG_ABOVE, '1, IMM_DROP));
        // due-at-zero entry first, then the cancelled one is not yet due
        send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
        // at tick 1 the cancelled entry drops and the rest are still early
        send_beat(make_req(FUNC_TICK, '0, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_TICK, '0, URG_LOW, '0, IMM_GRACEFUL));
        repeat (4) send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
        // the id cancelled before issue must come out normally
        repeat (2) send_beat(make_req(FUNC_SCHEDULE, '0, URG_NORMAL, '0, IMM_GRACEFUL));
        repeat (2) send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_BAD_LAST, '0, URG_LOW, '0, IMM_GRACEFUL));
    endtask

    // Limit zero rejects everything; limit one admits a single entry
    task automatic test_limit_extremes();
        write_limit(LIMIT_ZERO);
        send_beat(make_req(FUNC_SCHEDULE, '1, URG_ABOVE, '1, IMM_DROP));
        write_limit(5'd1);
        send_beat(make_req(FUNC_SCHEDULE, now_tick, URG_HIGH, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_SCHEDULE, now_tick, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
    endtask

    task automatic test_random_traffic(input int unsigned beats,
                                       input int unsigned tx_idle,
                                       input int unsigned rx_idle,
                                       input logic [LIMIT_W-1:0] limit);
        write_limit(limit);
        src_idle_pct = tx_idle;
        snk_idle_pct = rx_idle;
        repeat (beats) send_beat(draw_request());
    endtask

    // Hold results off long enough that the block stops taking requests,
    // keep offering meanwhile, then pause until everything is back
    task automatic test_result_backpressure();
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        rx_hold_cycles = 300;
        repeat (12) send_beat(draw_request());
        wait_drained();
    endtask

    // Graceful drain to a stop, then repeated and immediate shutdowns
    task automatic test_shutdown_modes();
        int unsigned guard;
        job_req_t    r;
        src_idle_pct = 14;
        snk_idle_pct = 30;
        r = draw_request();
        // make everything due, then empty the table
        r.func = FUNC_TICK;
        repeat (10) send_beat(r);
        r.func = FUNC_TAKE;
        guard = 0;
        while (live_count() != 0 && guard < 40)
        begin
            send_beat(r);
            guard++;
        end
        // three fresh entries, the middle one cancelled
        repeat (3) send_beat(make_req(FUNC_SCHEDULE, now_tick, PRIO_W'($urandom),
                                      $urandom, 1'($urandom)));
        send_beat(make_req(FUNC_CANCEL, $urandom, URG_LOW, next_id - 2'd2, IMM_DROP));
        send_beat(make_req(FUNC_SHUTDOWN, $urandom, URG_HIGH, $urandom, IMM_GRACEFUL));
        // no longer accepting: schedule and cancel are refused
        send_beat(make_req(FUNC_SCHEDULE, now_tick, URG_HIGH, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_CANCEL, '0, URG_LOW, next_id - 1'b1, IMM_GRACEFUL));
        // drain: two jobs, then the empty table stops the block, then stopped
        repeat (4) send_beat(make_req(FUNC_TAKE, $urandom, URG_LOW, $urandom, IMM_DROP));
        send_beat(make_req(FUNC_SHUTDOWN, '0, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_SHUTDOWN, '1, URG_ABOVE, '1, IMM_DROP));
        send_beat(make_req(FUNC_TICK, '0, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_BAD_FIRST, '0, URG_LOW, '0, IMM_GRACEFUL));
        send_beat(make_req(FUNC_TAKE, '0, URG_LOW, '0, IMM_GRACEFUL));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        req_bus.valid          = 1'b0;
        req_bus.func           = FUNC_TICK;
        req_bus.due_tick       = '0;
        req_bus.urgency        = URG_LOW;
        req_bus.target_id      = '0;
        req_bus.immediate_mode = IMM_GRACEFUL;
        src_idle_pct           = 0;
        snk_idle_pct           = 0;
        rx_hold_cycles         = 0;
        mismatch_total         = 0;
        cycle_count            = 0;
        // shadow state after reset
        for (i = 0; i < DEPTH; i++)
            tbl_live[i] = 1'b0;
        next_id        = IDENT_FIRST;
        now_tick       = '0;
        accepting      = 1'b1;
        halted         = 1'b0;
        drain_graceful = 1'b1;
        limit_reg      = LIMIT_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ordering();
        test_limit_extremes();
        test_random_traffic(350, 14, 62, LIMIT_MAX);
        test_result_backpressure();
        test_random_traffic(350, 62, 14, 5'd4);
        test_random_traffic(320, 0, 0, LIMIT_RESET);
        test_shutdown_modes();

        // let any stray beat show up before deciding
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_total == 0)
            $display("timed_priority_job_queue_core test passed");
        else
            $display("timed_priority_job_queue_core test failed");
        $finish;
    end

endmodule
